// ===== hdl/ptd_pkg.sv =====
// Package for the periodic task dispatcher: command and status codes,
// controller states and the bus types shared by the cells.
`timescale 1ns / 1ps
package ptd_pkg;

    localparam logic [2:0] CMD_REGISTER   = 3'd0;
    localparam logic [2:0] CMD_UNREGISTER = 3'd1;
    localparam logic [2:0] CMD_START      = 3'd2;
    localparam logic [2:0] CMD_TICK       = 3'd3;
    localparam logic [2:0] CMD_POLL       = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_RANGE     = 3'd2;
    localparam logic [2:0] ST_IDLE_SLOT = 3'd3;
    localparam logic [2:0] ST_NO_TASKS  = 3'd4;
    localparam logic [2:0] ST_STARTED   = 3'd5;

    localparam int START_OFFSET = 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } ctl_state_t;

    // Command broadcast from the controller to every cell for one cycle.
    typedef struct packed {
        logic write;    // write registration into the addressed cell
        logic clear;    // unregister the addressed cell
        logic add_base; // start: add base to every active due time
        logic advance;  // dispatch: add period to the addressed cell
    } cell_ctl_t;

endpackage

// ===== hdl/ptd_cell.sv =====
// One table slot of the dispatcher, chained with its neighbors to form the
// selection scan. Depends on ptd_pkg.
`timescale 1ns / 1ps
module ptd_cell
    import ptd_pkg::*;
#(
    parameter int TIME_BITS     = 32,
    parameter int PRIORITY_BITS = 8,
    parameter int IDX_BITS      = 4,
    parameter int SLOT_ID       = 0
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_ctl_t                ctl,
    input  logic [IDX_BITS-1:0]      addr,
    input  logic [TIME_BITS-1:0]     wr_due,
    input  logic [TIME_BITS-1:0]     wr_period,
    input  logic [PRIORITY_BITS-1:0] wr_prio,
    input  logic [31:0]              wr_arg,
    input  logic [TIME_BITS-1:0]     base,
    input  logic                     scan_clr,
    // chain in from the lower neighbor
    input  logic                     in_valid,
    input  logic [TIME_BITS-1:0]     in_due,
    input  logic [PRIORITY_BITS-1:0] in_prio,
    input  logic [IDX_BITS-1:0]      in_idx,
    input  logic [31:0]              in_arg,
    // chain out, registered
    output logic                     out_valid,
    output logic [TIME_BITS-1:0]     out_due,
    output logic [PRIORITY_BITS-1:0] out_prio,
    output logic [IDX_BITS-1:0]      out_idx,
    output logic [31:0]              out_arg,
    output logic                     active
);

    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(SLOT_ID);

    logic                     active_reg;
    logic [TIME_BITS-1:0]     due_reg;
    logic [TIME_BITS-1:0]     period_reg;
    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [31:0]              arg_reg;
    logic                     ov_reg;
    logic [TIME_BITS-1:0]     od_reg;
    logic [PRIORITY_BITS-1:0] op_reg;
    logic [IDX_BITS-1:0]      oi_reg;
    logic [31:0]              oa_reg;
    logic                     take;
    logic [TIME_BITS-1:0]     diff;
    logic                     hit;

    assign hit  = (addr == MY_IDX);
    assign diff = due_reg - in_due;

    always_comb
    begin
        take = 1'b0;
        if (active_reg) begin
            if (!in_valid)
                take = 1'b1;
            else if (diff[TIME_BITS-1])
                take = 1'b1;
            else if (due_reg == in_due && prio_reg > in_prio)
                take = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end else begin
            if (ctl.write && hit)
                active_reg <= 1'b1;
            else if (ctl.clear && hit)
                active_reg <= 1'b0;
            if (scan_clr)
                ov_reg <= 1'b0;
            else
                ov_reg <= in_valid | active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.write && hit) begin
            due_reg    <= wr_due;
            period_reg <= wr_period;
            prio_reg   <= wr_prio;
            arg_reg    <= wr_arg;
        end else if (ctl.add_base && active_reg) begin
            due_reg <= due_reg + base;
        end else if (ctl.advance && hit) begin
            due_reg <= due_reg + period_reg;
        end
        if (take) begin
            od_reg <= due_reg;
            op_reg <= prio_reg;
            oi_reg <= MY_IDX;
            oa_reg <= arg_reg;
        end else begin
            od_reg <= in_due;
            op_reg <= in_prio;
            oi_reg <= in_idx;
            oa_reg <= in_arg;
        end
    end

    assign out_valid = ov_reg;
    assign out_due   = od_reg;
    assign out_prio  = op_reg;
    assign out_idx   = oi_reg;
    assign out_arg   = oa_reg;
    assign active    = active_reg;

endmodule

// ===== hdl/periodic_task_dispatcher.sv =====
// Periodic task dispatcher top level: command controller plus a chain of
// slot cells that scans for the earliest due task. Depends on ptd_pkg, ptd_cell.
//
// Usage: drive command and its fields with start high while busy is low;
// the item is taken at that edge and busy rises. Exactly one result follows,
// shown on status, slot_index, dispatched, dispatch_argument and
// active_count for one cycle with done high. The receiver cannot stall.
// Register, unregister and start pass through S_DONE only. Tick and poll, once
// started with tasks registered, run the selection through the slot chain:
// one cell per cycle, in S_DONE and then S_SCAN. Busy is low again in the cycle
// done is high, so the next item may be taken then.
// Reset empties the table, stops the dispatcher and zeroes the tick count;
// no clearing pass is needed, slot entries are guarded by active bits.
`timescale 1ns / 1ps
module periodic_task_dispatcher
    import ptd_pkg::*;
#(
    parameter int TABLE_SLOTS   = 16,
    parameter int TIME_BITS     = 32,
    parameter int PRIORITY_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [7:0]  slot_select,
    input  logic [31:0] initial_delay,
    input  logic [31:0] run_period,
    input  logic [7:0]  task_priority,
    input  logic [31:0] task_argument,
    output logic        done,
    output logic [2:0]  status,
    output logic [5:0]  slot_index,
    output logic        dispatched,
    output logic [31:0] dispatch_argument,
    output logic [6:0]  active_count
);

    localparam int IDX_BITS = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_BITS = $clog2(TABLE_SLOTS + 1);
    localparam int SCAN_BITS = $clog2(TABLE_SLOTS + 2);

    ctl_state_t               state_reg, state_next;
    logic [TIME_BITS-1:0]     now_reg;
    logic                     started_reg;
    logic [CNT_BITS-1:0]      total_reg;
    logic [SCAN_BITS-1:0]     scan_reg;
    logic [2:0]               cmd_reg;
    logic [7:0]               sel_reg;
    logic [TIME_BITS-1:0]     delay_reg;
    logic [TIME_BITS-1:0]     period_reg;
    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [31:0]              arg_reg;
    logic [2:0]               status_reg, status_next;
    logic [5:0]               slot_reg, slot_next;
    logic                     disp_reg, disp_next;
    logic [31:0]              darg_reg, darg_next;
    logic                     done_reg;

    cell_ctl_t                ctl;
    logic [IDX_BITS-1:0]      addr;
    logic [IDX_BITS-1:0]      free_idx;
    logic                     free_found;
    logic [TABLE_SLOTS-1:0]   act;
    logic                     scan_clr;
    logic [TIME_BITS-1:0]     base;
    logic [TIME_BITS-1:0]     wr_due;

    logic                     ch_v [TABLE_SLOTS+1];
    logic [TIME_BITS-1:0]     ch_d [TABLE_SLOTS+1];
    logic [PRIORITY_BITS-1:0] ch_p [TABLE_SLOTS+1];
    logic [IDX_BITS-1:0]      ch_i [TABLE_SLOTS+1];
    logic [31:0]              ch_a [TABLE_SLOTS+1];

    logic                     accept;
    logic [TIME_BITS-1:0]     tdiff;
    logic                     sel_ok;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign base   = now_reg + TIME_BITS'(START_OFFSET);
    assign wr_due = started_reg ? (delay_reg + now_reg) : delay_reg;
    assign sel_ok = (sel_reg < 8'(TABLE_SLOTS));

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
            if (!act[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_BITS'(i);
            end
        end
    end

    assign ch_v[0] = 1'b0;
    assign ch_d[0] = '0;
    assign ch_p[0] = '0;
    assign ch_i[0] = '0;
    assign ch_a[0] = '0;

    genvar g;
    generate
        for (g = 0; g < TABLE_SLOTS; g++) begin : g_cell
            ptd_cell #(
                .TIME_BITS    (TIME_BITS),
                .PRIORITY_BITS(PRIORITY_BITS),
                .IDX_BITS     (IDX_BITS),
                .SLOT_ID      (g)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .addr     (addr),
                .wr_due   (wr_due),
                .wr_period(period_reg),
                .wr_prio  (prio_reg),
                .wr_arg   (arg_reg),
                .base     (base),
                .scan_clr (scan_clr),
                .in_valid (ch_v[g]),
                .in_due   (ch_d[g]),
                .in_prio  (ch_p[g]),
                .in_idx   (ch_i[g]),
                .in_arg   (ch_a[g]),
                .out_valid(ch_v[g+1]),
                .out_due  (ch_d[g+1]),
                .out_prio (ch_p[g+1]),
                .out_idx  (ch_i[g+1]),
                .out_arg  (ch_a[g+1]),
                .active   (act[g])
            );
        end
    endgenerate

    assign tdiff = now_reg - ch_d[TABLE_SLOTS];

    // Controller: next state and cell commands.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        addr       = free_idx;
        scan_clr   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                scan_clr = 1'b1;
                if (accept)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                scan_clr = 1'b1;
                case (cmd_reg)
                    CMD_REGISTER:
                    begin
                        ctl.write = free_found;
                    end
                    CMD_UNREGISTER:
                    begin
                        addr      = sel_reg[IDX_BITS-1:0];
                        ctl.clear = sel_ok && act[sel_reg[IDX_BITS-1:0]];
                    end
                    CMD_START:
                    begin
                        ctl.add_base = !started_reg && (total_reg != '0);
                    end
                    default:
                    begin
                    end
                endcase
                if ((cmd_reg == CMD_TICK || cmd_reg == CMD_POLL) && started_reg
                    && total_reg != '0)
                    state_next = S_SCAN;
                else
                    state_next = S_IDLE;
            end
            S_SCAN:
            begin
                addr = ch_i[TABLE_SLOTS];
                if (scan_reg == SCAN_BITS'(TABLE_SLOTS)) begin
                    ctl.advance = !tdiff[TIME_BITS-1];
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result fields for the item in flight.
    always_comb
    begin
        status_next = status_reg;
        slot_next   = slot_reg;
        disp_next   = disp_reg;
        darg_next   = darg_reg;
        if (state_reg == S_DONE) begin
            status_next = ST_OK;
            slot_next   = '0;
            disp_next   = 1'b0;
            darg_next   = '0;
            case (cmd_reg)
                CMD_REGISTER:
                begin
                    if (free_found)
                        slot_next = 6'(free_idx);
                    else
                        status_next = ST_FULL;
                end
                CMD_UNREGISTER:
                begin
                    if (!sel_ok)
                        status_next = ST_RANGE;
                    else if (!act[sel_reg[IDX_BITS-1:0]])
                        status_next = ST_IDLE_SLOT;
                    else
                        slot_next = 6'(sel_reg[IDX_BITS-1:0]);
                end
                CMD_START:
                begin
                    if (started_reg)
                        status_next = ST_STARTED;
                    else if (total_reg == '0)
                        status_next = ST_NO_TASKS;
                end
                CMD_TICK, CMD_POLL:
                begin
                    if (!started_reg || total_reg == '0)
                        status_next = ST_NO_TASKS;
                end
                default:
                begin
                end
            endcase
        end
        if (state_reg == S_SCAN && ctl.advance) begin
            slot_next = 6'(ch_i[TABLE_SLOTS]);
            disp_next = 1'b1;
            darg_next = ch_a[TABLE_SLOTS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            now_reg     <= '0;
            started_reg <= 1'b0;
            total_reg   <= '0;
            scan_reg    <= '0;
            done_reg    <= 1'b0;
        end else begin
            done_reg <= (state_reg != S_IDLE) && (state_next == S_IDLE);
            if (accept && command == CMD_TICK)
                now_reg <= now_reg + 1'b1;
            if (state_reg == S_SCAN)
                scan_reg <= scan_reg + 1'b1;
            else
                scan_reg <= '0;
            if (state_reg == S_DONE) begin
                if (ctl.write)
                    total_reg <= total_reg + 1'b1;
                if (ctl.clear)
                    total_reg <= total_reg - 1'b1;
                if (ctl.add_base)
                    started_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            cmd_reg    <= command;
            sel_reg    <= slot_select;
            delay_reg  <= TIME_BITS'(initial_delay);
            period_reg <= TIME_BITS'(run_period);
            prio_reg   <= PRIORITY_BITS'(task_priority);
            arg_reg    <= task_argument;
        end
        status_reg <= status_next;
        slot_reg   <= slot_next;
        disp_reg   <= disp_next;
        darg_reg   <= darg_next;
    end

    assign done              = done_reg;
    assign status            = status_reg;
    assign slot_index        = slot_reg;
    assign dispatched        = disp_reg;
    assign dispatch_argument = darg_reg;
    assign active_count      = 7'(total_reg);

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg == CNT_BITS'($countones(act)))
        else $error("active count mismatch");
    a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$past(done))
        else $error("back to back results");
    a_disp_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && dispatched) |-> status == ST_OK)
        else $error("dispatch with bad status");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item taken without busy");
    a_scan_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && scan_reg == SCAN_BITS'(TABLE_SLOTS))
        |-> ch_v[TABLE_SLOTS])
        else $error("scan ended with no candidate");

endmodule

// ===== tb/sv/ptd_checker.sv =====
// Checker for the periodic task dispatcher: watches accepted commands and
// results, predicts each result from its own copy of the task table.
// Depends on ptd_pkg.
`timescale 1ns / 1ps
module ptd_checker
    import ptd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  command,
    input  logic [7:0]  slot_select,
    input  logic [31:0] initial_delay,
    input  logic [31:0] run_period,
    input  logic [7:0]  task_priority,
    input  logic [31:0] task_argument,
    input  logic        done,
    input  logic [2:0]  status,
    input  logic [5:0]  slot_index,
    input  logic        dispatched,
    input  logic [31:0] dispatch_argument,
    input  logic [6:0]  active_count,
    output int          fail_count,
    output int          pending_count,
    output int          dispatch_count
);
    localparam int SLOTS = 16;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic        disp;
        logic [31:0] arg;
        logic [6:0]  count;
    } outcome_t;

    outcome_t    outcome_q[$];
    logic [31:0] tick_now;
    logic        running;
    int          live_tasks;
    logic        live[SLOTS];
    logic [31:0] due[SLOTS];
    logic [31:0] period[SLOTS];
    logic [7:0]  prio[SLOTS];
    logic [31:0] argw[SLOTS];

    function automatic logic precedes(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic outcome_t select_due();
        outcome_t o;
        int best;
        o = '0;
        best = -1;
        if (!running || live_tasks == 0)
        begin
            o.status = ST_NO_TASKS;
            return o;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!live[i])
                continue;
            if (best < 0 || precedes(due[i], due[best])
                || (due[i] == due[best] && prio[i] > prio[best]))
                best = i;
        end
        o.status = ST_OK;
        if (!precedes(tick_now, due[best]))
        begin
            o.slot = best[5:0];
            o.disp = 1'b1;
            o.arg  = argw[best];
            due[best] = due[best] + period[best];
        end
        return o;
    endfunction

    function automatic outcome_t apply_command(logic [2:0] cmd, logic [7:0] sel,
        logic [31:0] dly, logic [31:0] per, logic [7:0] pr, logic [31:0] a);
        outcome_t o;
        int free_slot;
        o = '0;
        free_slot = -1;
        case (cmd)
            CMD_REGISTER:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (!live[i] && free_slot < 0)
                        free_slot = i;
                if (free_slot < 0)
                    o.status = ST_FULL;
                else
                begin
                    due[free_slot]    = running ? dly + tick_now : dly;
                    period[free_slot] = per;
                    prio[free_slot]   = pr;
                    argw[free_slot]   = a;
                    live[free_slot]   = 1'b1;
                    live_tasks++;
                    o.slot = free_slot[5:0];
                end
            end
            CMD_UNREGISTER:
            begin
                if (sel >= SLOTS)
                    o.status = ST_RANGE;
                else if (!live[sel])
                    o.status = ST_IDLE_SLOT;
                else
                begin
                    live[sel] = 1'b0;
                    live_tasks--;
                    o.slot = sel[5:0];
                end
            end
            CMD_START:
            begin
                if (running)
                    o.status = ST_STARTED;
                else if (live_tasks == 0)
                    o.status = ST_NO_TASKS;
                else
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (live[i])
                            due[i] = due[i] + tick_now + START_OFFSET;
                    running = 1'b1;
                end
            end
            CMD_TICK:
            begin
                tick_now = tick_now + 1;
                o = select_due();
            end
            CMD_POLL:
                o = select_due();
            default: ;
        endcase
        o.count = live_tasks[6:0];
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t o;
        if (!rst_n)
        begin
            outcome_q.delete();
            tick_now = '0;
            running = 1'b0;
            live_tasks = 0;
            fail_count = 0;
            pending_count = 0;
            dispatch_count = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                live[i] = 1'b0;
                due[i] = '0;
                period[i] = '0;
                prio[i] = '0;
                argw[i] = '0;
            end
        end
        else
        begin
            if (done)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("result with no item outstanding");
                    fail_count++;
                end
                else
                begin
                    o = outcome_q.pop_front();
                    if (status !== o.status)
                    begin
                        $error("status exp %0d got %0d", o.status, status);
                        fail_count++;
                    end
                    if (slot_index !== o.slot)
                    begin
                        $error("slot_index exp %0d got %0d", o.slot, slot_index);
                        fail_count++;
                    end
                    if (dispatched !== o.disp)
                    begin
                        $error("dispatched exp %0d got %0d", o.disp, dispatched);
                        fail_count++;
                    end
                    if (dispatch_argument !== o.arg)
                    begin
                        $error("dispatch_argument exp %h got %h", o.arg,
                            dispatch_argument);
                        fail_count++;
                    end
                    if (active_count !== o.count)
                    begin
                        $error("active_count exp %0d got %0d", o.count, active_count);
                        fail_count++;
                    end
                    if (o.disp)
                        dispatch_count++;
                end
            end
            if (start && !busy)
                outcome_q.push_back(apply_command(command, slot_select, initial_delay,
                    run_period, task_priority, task_argument));
            pending_count = outcome_q.size();
        end
    end
endmodule

// ===== tb/sv/tb_periodic_task_dispatcher.sv =====
// Testbench top for the periodic task dispatcher: clock, reset, directed and
// random command items, verdict. Depends on ptd_pkg, ptd_checker and the block.
`timescale 1ns / 1ps
module tb_periodic_task_dispatcher
    import ptd_pkg::*;
;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  command;
    logic [7:0]  slot_select;
    logic [31:0] initial_delay;
    logic [31:0] run_period;
    logic [7:0]  task_priority;
    logic [31:0] task_argument;
    logic        done;
    logic [2:0]  status;
    logic [5:0]  slot_index;
    logic        dispatched;
    logic [31:0] dispatch_argument;
    logic [6:0]  active_count;
    int          fail_count;
    int          pending_count;
    int          dispatch_count;
    int          gap_pct;
    int          item_total;
    int          wait_cycles;

    periodic_task_dispatcher dut (.*);
    ptd_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic send(logic [2:0] cmd, logic [7:0] sel, logic [31:0] dly,
        logic [31:0] per, logic [7:0] pr, logic [31:0] a);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        while (busy)
            @(negedge clk);
        start <= 1'b1;
        command <= cmd;
        slot_select <= sel;
        initial_delay <= dly;
        run_period <= per;
        task_priority <= pr;
        task_argument <= a;
        @(negedge clk);
        start <= 1'b0;
        item_total++;
    endtask

    task automatic register_task(logic [31:0] dly, logic [31:0] per, logic [7:0] pr);
        send(CMD_REGISTER, 8'($urandom), dly, per, pr, $urandom);
    endtask

    task automatic random_item(bit noisy);
        int r;
        r = $urandom_range(99);
        if (noisy && r < 8)
            send(3'($urandom_range(7)), 8'($urandom), $urandom, $urandom,
                8'($urandom), $urandom);
        else if (r < 20)
            register_task($urandom_range(1) ? $urandom_range(12) : $urandom,
                $urandom_range(3) ? $urandom_range(9) : $urandom,
                8'($urandom_range(1) ? $urandom_range(3) : $urandom));
        else if (r < 28)
            send(CMD_UNREGISTER, 8'($urandom_range(5) ? $urandom_range(15) : $urandom),
                $urandom, $urandom, 8'($urandom), $urandom);
        else if (r < 31)
            send(CMD_START, 8'($urandom), $urandom, $urandom, 8'($urandom), $urandom);
        else if (r < 80)
            send(CMD_TICK, 8'($urandom), $urandom, $urandom, 8'($urandom), $urandom);
        else
            send(CMD_POLL, 8'($urandom), $urandom, $urandom, 8'($urandom), $urandom);
    endtask

    initial
    begin
        #20_000_000;
        $display("periodic_task_dispatcher regression: fail");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_POLL;
        slot_select = '0;
        initial_delay = '0;
        run_period = '0;
        task_priority = '0;
        task_argument = '0;
        gap_pct = 0;
        item_total = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty table cases, fill to full, extremes, wrap
        send(CMD_POLL, 0, 0, 0, 0, 0);
        send(CMD_TICK, 0, 0, 0, 0, 0);
        send(CMD_START, 0, 0, 0, 0, 0);
        send(CMD_UNREGISTER, 8'hFF, 0, 0, 0, 0);
        send(CMD_UNREGISTER, 16, 0, 0, 0, 0);
        send(CMD_UNREGISTER, 3, 0, 0, 0, 0);
        send(3'd5, 0, 0, 0, 0, 0);
        send(3'd7, 8'hFF, '1, '1, '1, '1);
        send(CMD_REGISTER, 0, 32'hFFFF_FFFD, 32'hFFFF_FFFF, 8'hFF, '1);
        send(CMD_REGISTER, 0, 0, 0, 0, 0);
        send(CMD_REGISTER, 0, 32'hFFFF_FFFD, 1, 8'h00, 32'h5A5A_A5A5);
        for (int i = 0; i < 13; i++)
            register_task(i, i + 1, i[7:0]);
        send(CMD_REGISTER, 0, 1, 1, 1, 1);
        send(CMD_UNREGISTER, 15, 0, 0, 0, 0);
        send(CMD_START, 0, 0, 0, 0, 0);
        send(CMD_START, 0, 0, 0, 0, 0);
        send(CMD_POLL, 0, 0, 0, 0, 0);
        send(CMD_TICK, 0, 0, 0, 0, 0);
        send(CMD_REGISTER, 0, '1, 2, 8'h80, '1);

        // random phases: no gaps, sender gaps, short sessions
        for (int ph = 0; ph < 4; ph++)
        begin
            gap_pct = (ph == 1) ? 45 : (ph == 2) ? 11 : 0;
            for (int k = 0; k < 500; k++)
            begin
                if (ph >= 2 && k % 100 == 0)
                begin
                    for (int s = 0; s < 16; s++)
                        send(CMD_UNREGISTER, 8'(s), 0, 0, 0, 0);
                    repeat ($urandom_range(3) + 1)
                        random_item(0);
                end
                random_item(ph != 0);
            end
        end

        wait_cycles = 0;
        while (pending_count != 0 && wait_cycles < 1000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (30) @(posedge clk);
        $display("Ran %0d command items; %0d task dispatches checked.",
            item_total, dispatch_count);
        if (fail_count == 0 && pending_count == 0)
            $display("periodic_task_dispatcher regression: pass");
        else
            $display("periodic_task_dispatcher regression: fail");
        $finish;
    end
endmodule
